>>> rtl/core/ugb_pkg.sv
// ============================================================================
// ugb_pkg
// Types, command codes and defaults shared by the uniform grid broadphase.
// ============================================================================
package ugb_pkg;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_CELL_WIDTH   = 2'd0;
    localparam logic [1:0] REG_CELL_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CELLS_ACROSS = 2'd2;
    localparam logic [1:0] REG_CELLS_DOWN   = 2'd3;

    // Parameter defaults
    localparam int DEF_MAX_NODES   = 64;
    localparam int DEF_MAX_CELLS_X = 16;
    localparam int DEF_MAX_CELLS_Y = 16;

    // Register reset values
    localparam logic [15:0] RST_CELL_WIDTH   = 16'd64;
    localparam logic [15:0] RST_CELL_HEIGHT  = 16'd64;
    localparam logic [4:0]  RST_CELLS_ACROSS = 5'd16;
    localparam logic [4:0]  RST_CELLS_DOWN   = 5'd16;

    // Dividend magnitude bits, one quotient bit per divider step
    localparam int DIV_STEPS = 20;

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         node_number;
        logic signed [19:0] rect_x;
        logic signed [19:0] rect_y;
        logic [18:0]        rect_width;
        logic [18:0]        rect_height;
    } t_cmd_in;

    typedef struct packed {
        logic [63:0] node_mask;
        logic [1:0]  done_command;
    } t_result;

endpackage

>>> rtl/core/uniform_grid_broadphase.sv
// ============================================================================
// uniform_grid_broadphase
// Uniform grid of cells, each holding a node bitmask; insert, remove, query
// and clear commands over the cells that a rectangle covers.
// ============================================================================
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------
//  in        in         i_in_valid / o_in_ready   i_in_data  (t_cmd_in)
//  out       out        o_out_valid / i_out_ready o_out_data (t_result)
//  cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  Order: a clear, or an insert or remove for a node at or above MAX_NODES,
//  goes straight to the final state and loads its result there. Every other
//  command runs four corner divisions that share one restoring divider at one
//  quotient bit per cycle, then scans the covered cells (none when the range is
//  empty), one cell per cycle through the read port and write port of the cell
//  memory, and loads its result. The next command is taken the cycle after
//  the result loads.
//  Reset: synchronous, active low; cell valid flags clear at once, so no
//  clearing pass is needed. Stalls: a result waits in the output register
//  while the next command is taken; the block holds in its final state only
//  while that register is still full.
//
module uniform_grid_broadphase
    import ugb_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int MAX_CELLS_X = DEF_MAX_CELLS_X,
    parameter int MAX_CELLS_Y = DEF_MAX_CELLS_Y
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_cmd_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int DEPTH  = MAX_CELLS_X * MAX_CELLS_Y;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CX_W   = $clog2(MAX_CELLS_X + 1);
    localparam int CY_W   = $clog2(MAX_CELLS_Y + 1);
    localparam int PROD_W = CX_W + CY_W;
    localparam int CNT_W  = $clog2(DIV_STEPS + 1);

    // State codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DLOAD  = 3'd1;
    localparam logic [2:0] ST_DSTEP  = 3'd2;
    localparam logic [2:0] ST_DSTORE = 3'd3;
    localparam logic [2:0] ST_SETUP  = 3'd4;
    localparam logic [2:0] ST_SCAN   = 3'd5;
    localparam logic [2:0] ST_DRAIN  = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_cell_width, r_cell_height;
    logic [4:0]  r_cells_across, r_cells_down;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width   <= RST_CELL_WIDTH;
            r_cell_height  <= RST_CELL_HEIGHT;
            r_cells_across <= RST_CELLS_ACROSS;
            r_cells_down   <= RST_CELLS_DOWN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CELL_WIDTH:   r_cell_width   <= i_cfg_data;
                REG_CELL_HEIGHT:  r_cell_height  <= i_cfg_data;
                REG_CELLS_ACROSS: r_cells_across <= i_cfg_data[4:0];
                REG_CELLS_DOWN:   r_cells_down   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Effective grid size: zero counts as one, saturate at the parameter.
    logic [CX_W-1:0] w_nx;
    logic [CY_W-1:0] w_ny;

    always_comb begin
        if (r_cells_across == 5'd0) begin
            w_nx = CX_W'(1);
        end else if (32'(r_cells_across) > MAX_CELLS_X) begin
            w_nx = CX_W'(MAX_CELLS_X);
        end else begin
            w_nx = CX_W'(r_cells_across);
        end
        if (r_cells_down == 5'd0) begin
            w_ny = CY_W'(1);
        end else if (32'(r_cells_down) > MAX_CELLS_Y) begin
            w_ny = CY_W'(MAX_CELLS_Y);
        end else begin
            w_ny = CY_W'(r_cells_down);
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic [2:0]       r_state, n_state;
    t_cmd_in          r_cmd;
    logic [1:0]       r_div_sel;
    logic [CNT_W-1:0] r_div_cnt;
    logic [15:0]      r_rem;
    logic [19:0]      r_quo;
    logic             r_neg;
    logic             r_empty;
    logic [CX_W-1:0]  r_x0, r_x1, r_cx;
    logic [CY_W-1:0]  r_y0, r_y1, r_cy;
    logic [ADDR_W-1:0] r_row_base;
    logic             r_rd_pend;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [MAX_NODES-1:0] r_acc;
    logic             r_out_valid;
    t_result          r_out_data;
    logic             r_out_valid_prev_clear;

    logic w_in_fire, w_load_out, w_is_clear;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign w_is_clear  = (r_cmd.command == CMD_CLEAR);
    assign w_load_out  = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);

    // ------------------------------------------------------------------
    // Corner divider: sel 0 x, 1 x+width, 2 y, 3 y+height
    // ------------------------------------------------------------------
    logic [20:0] w_dvd, w_dvd_mag;
    logic [15:0] w_dvs;
    logic [16:0] w_rem_sh;
    logic [17:0] w_diff;

    always_comb begin
        case (r_div_sel)
            2'd0: w_dvd = {r_cmd.rect_x[19], r_cmd.rect_x};
            2'd1: w_dvd = {r_cmd.rect_x[19], r_cmd.rect_x} + {2'b00, r_cmd.rect_width};
            2'd2: w_dvd = {r_cmd.rect_y[19], r_cmd.rect_y};
            default: w_dvd = {r_cmd.rect_y[19], r_cmd.rect_y} + {2'b00, r_cmd.rect_height};
        endcase
        w_dvd_mag = w_dvd[20] ? (~w_dvd + 21'd1) : w_dvd;
        w_dvs     = r_div_sel[1] ? r_cell_height : r_cell_width;
        if (w_dvs == 16'd0) begin
            w_dvs = 16'd1;
        end
        w_rem_sh = {r_rem, r_quo[19]};
        w_diff   = {1'b0, w_rem_sh} - {2'b00, w_dvs};
    end

    // Clamp the finished quotient for the axis bound it belongs to.
    logic            w_upper, w_axis_y;
    logic [31:0]     w_cnt_m1;
    logic [31:0]     w_lim;
    logic [CX_W-1:0] w_bound_x;
    logic [CY_W-1:0] w_bound_y;
    logic            w_bound_empty;

    always_comb begin
        w_upper       = r_div_sel[0];
        w_axis_y      = r_div_sel[1];
        w_cnt_m1      = w_axis_y ? (32'(w_ny) - 32'd1) : (32'(w_nx) - 32'd1);
        w_lim         = w_axis_y ? 32'(MAX_CELLS_Y) : 32'(MAX_CELLS_X);
        w_bound_x     = '0;
        w_bound_y     = '0;
        w_bound_empty = 1'b0;
        if (!w_upper) begin
            // Lower corner: negative truncates to zero or below, clamp at 0;
            // far beyond the grid saturate to a value past any upper bound.
            if (!r_neg) begin
                w_bound_x = (32'(r_quo) > w_lim) ? CX_W'(MAX_CELLS_X) : CX_W'(r_quo);
                w_bound_y = (32'(r_quo) > w_lim) ? CY_W'(MAX_CELLS_Y) : CY_W'(r_quo);
            end
        end else begin
            // Upper corner: a negative quotient leaves nothing covered.
            if (r_neg && (r_quo != 20'd0)) begin
                w_bound_empty = 1'b1;
            end
            w_bound_x = (32'(r_quo) > w_cnt_m1) ? CX_W'(w_cnt_m1) : CX_W'(r_quo);
            w_bound_y = (32'(r_quo) > w_cnt_m1) ? CY_W'(w_cnt_m1) : CY_W'(r_quo);
        end
    end

    // ------------------------------------------------------------------
    // Scan addressing and read-modify-write data path
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]   w_row0;
    logic [ADDR_W-1:0]   w_addr;
    logic [MAX_NODES-1:0] w_bit, w_cell, w_wdata;
    logic                w_we;
    logic [MAX_NODES-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]    r_cell_vld;
    logic [MAX_NODES-1:0] r_rd_data;
    logic                r_rd_vld;

    assign w_row0 = PROD_W'(r_y0) * PROD_W'(w_nx);
    assign w_addr = r_row_base + ADDR_W'(r_cx);
    assign w_bit  = MAX_NODES'(1) << r_cmd.node_number;
    assign w_cell = r_rd_vld ? r_rd_data : '0;
    assign w_we   = r_rd_pend &&
                    ((r_cmd.command == CMD_INSERT) || (r_cmd.command == CMD_REMOVE));
    assign w_wdata = (r_cmd.command == CMD_INSERT) ? (w_cell | w_bit) : (w_cell & ~w_bit);

    // Cell memory: one write and one registered read per cycle. Within a
    // command every cell is visited once, so the write-back of one cell
    // never meets the read of the same cell.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_rd_addr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_addr];
    end

    // Valid flags: an entry never written since reset or clear reads zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_rd_vld <= r_cell_vld[w_addr];
            if ((r_state == ST_FINISH) && w_is_clear && !r_out_valid_prev_clear) begin
                r_cell_vld <= '0;
            end else if (w_we) begin
                r_cell_vld[r_rd_addr] <= 1'b1;
            end
        end
    end

    // Clear acts once, on the first cycle in the final state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid_prev_clear <= 1'b0;
        end else begin
            r_out_valid_prev_clear <= (r_state == ST_FINISH) && !w_load_out;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic w_last_col, w_last_row;

    assign w_last_col = (r_cx == r_x1);
    assign w_last_row = (r_cy == r_y1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    if (i_in_data.command == CMD_CLEAR) begin
                        n_state = ST_FINISH;
                    end else if ((i_in_data.command != CMD_QUERY) &&
                                 !(32'(i_in_data.node_number) < MAX_NODES)) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_DLOAD;
                    end
                end
            end
            ST_DLOAD:  n_state = ST_DSTEP;
            ST_DSTEP: begin
                if (r_div_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DSTORE;
                end
            end
            ST_DSTORE: n_state = (r_div_sel == 2'd3) ? ST_SETUP : ST_DLOAD;
            ST_SETUP: begin
                if (r_empty || (r_x0 > r_x1) || (32'(r_y0) > 32'(r_y1))) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_last_col && w_last_row) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_FINISH;
            ST_FINISH: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_div_sel   <= '0;
            r_div_cnt   <= '0;
            r_empty     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == ST_SCAN);

            // Load a new result, else drop the one just taken.
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    r_div_sel <= '0;
                    r_empty   <= 1'b0;
                end
                ST_DLOAD:  r_div_cnt <= '0;
                ST_DSTEP:  r_div_cnt <= r_div_cnt + CNT_W'(1);
                ST_DSTORE: begin
                    r_div_sel <= r_div_sel + 2'd1;
                    if (w_bound_empty) begin
                        r_empty <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload and data path registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd <= i_in_data;
            r_acc <= '0;
        end

        case (r_state)
            ST_DLOAD: begin
                r_rem <= '0;
                r_quo <= w_dvd_mag[19:0];
                r_neg <= w_dvd[20];
            end
            ST_DSTEP: begin
                // Restoring step: subtract where it fits, shift in the bit.
                if (!w_diff[17]) begin
                    r_rem <= w_diff[15:0];
                    r_quo <= {r_quo[18:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh[15:0];
                    r_quo <= {r_quo[18:0], 1'b0};
                end
            end
            ST_DSTORE: begin
                case (r_div_sel)
                    2'd0:    r_x0 <= w_bound_x;
                    2'd1:    r_x1 <= w_bound_x;
                    2'd2:    r_y0 <= w_bound_y;
                    default: r_y1 <= w_bound_y;
                endcase
            end
            ST_SETUP: begin
                r_cx       <= r_x0;
                r_cy       <= r_y0;
                r_row_base <= ADDR_W'(w_row0);
            end
            ST_SCAN: begin
                // Advance along the row, wrap to the next row's base.
                r_rd_addr <= w_addr;
                if (w_last_col) begin
                    r_cx       <= r_x0;
                    r_cy       <= r_cy + CY_W'(1);
                    r_row_base <= r_row_base + ADDR_W'(w_nx);
                end else begin
                    r_cx <= r_cx + CX_W'(1);
                end
            end
            default: ;
        endcase

        if (r_rd_pend && (r_cmd.command == CMD_QUERY)) begin
            r_acc <= r_acc | w_cell;
        end

        if (w_load_out) begin
            r_out_data.done_command <= r_cmd.command;
            r_out_data.node_mask    <= (r_cmd.command == CMD_QUERY) ? 64'(r_acc) : 64'd0;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_rd_pend)
        else $error("command taken while a cell read is outstanding");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((r_cx <= r_x1) && (r_cy <= r_y1)))
        else $error("scan position beyond the covered range");

    a_write_only_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_cmd.command == CMD_INSERT) || (r_cmd.command == CMD_REMOVE)))
        else $error("cell write on a query or clear");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FINISH) && w_is_clear && !r_out_valid_prev_clear)
        |=> (r_cell_vld == '0))
        else $error("clear left cell flags set");

    a_load_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("result load did not return to idle");

endmodule
